// File: sv/cgs_pkg.sv
package cgs_pkg;

	// field widths of the item and result channels
	localparam int OPER_W  = 2;
	localparam int CIGOP_W = 4;
	localparam int ELEN_W  = 28;
	localparam int RLEN_W  = 16;
	localparam int RPOS_W  = 17;
	localparam int GPOS_W  = 25;
	localparam int ERR_W   = 2;

	// defaults for the top level parameters
	localparam int MAX_ELEMENTS_DEF = 64;
	localparam int GENOME_WIDTH_DEF = 25;

	// item operation codes
	localparam logic [OPER_W-1:0] OP_BEGIN  = 2'd0;
	localparam logic [OPER_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OPER_W-1:0] OP_STEP   = 2'd2;

	// cigar op codes
	localparam logic [CIGOP_W-1:0] CIG_M  = 4'd0;
	localparam logic [CIGOP_W-1:0] CIG_I  = 4'd1;
	localparam logic [CIGOP_W-1:0] CIG_D  = 4'd2;
	localparam logic [CIGOP_W-1:0] CIG_N  = 4'd3;
	localparam logic [CIGOP_W-1:0] CIG_S  = 4'd4;
	localparam logic [CIGOP_W-1:0] CIG_H  = 4'd5;
	localparam logic [CIGOP_W-1:0] CIG_P  = 4'd6;
	localparam logic [CIGOP_W-1:0] CIG_EQ = 4'd7;
	localparam logic [CIGOP_W-1:0] CIG_X  = 4'd8;
	// op reported when no element was stepped into
	localparam logic [CIGOP_W-1:0] CIG_NONE = 4'd0;

	// error codes
	localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
	localparam logic [ERR_W-1:0] ERR_DEL_FIRST = 2'd1;
	localparam logic [ERR_W-1:0] ERR_FULL      = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic simple;
		logic read;
		logic eval;
	} ctrl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic in_step;
		logic ev_term;
		logic ev_reread;
	} dp_status_t;

endpackage

// File: sv/cgs_in_if.sv
interface cgs_in_if;
	import cgs_pkg::*;

	logic                valid;
	logic                ready;
	logic [OPER_W-1:0]   operation;
	logic [CIGOP_W-1:0]  element_op;
	logic [ELEN_W-1:0]   element_length;
	logic [RLEN_W-1:0]   read_length;

	modport source (
		output valid, operation, element_op, element_length, read_length,
		input  ready
	);

	modport sink (
		input  valid, operation, element_op, element_length, read_length,
		output ready
	);

endinterface

// File: sv/cgs_out_if.sv
interface cgs_out_if;
	import cgs_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      past_end;
	logic [CIGOP_W-1:0]        step_op;
	logic signed [RPOS_W-1:0]  read_position;
	logic signed [GPOS_W-1:0]  genome_position;
	logic [ERR_W-1:0]          error_code;

	modport source (
		output valid, past_end, step_op, read_position, genome_position, error_code,
		input  ready
	);

	modport sink (
		input  valid, past_end, step_op, read_position, genome_position, error_code,
		output ready
	);

endinterface

// File: sv/cgs_ctrl.sv
module cgs_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	output cgs_pkg::ctrl_cmd_t     cmd,
	input  cgs_pkg::dp_status_t    status
);
	import cgs_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SIMPLE = 4'b0010,
		S_READ   = 4'b0100,
		S_EVAL   = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   slot_free;
	logic   load;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign load      = cmd.simple || (cmd.eval && status.ev_term);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = status.in_step ? S_READ : S_SIMPLE;
				end
			end
			S_SIMPLE: begin
				if (slot_free) begin
					cmd.simple = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			S_READ: begin
				cmd.read  = 1'b1;
				state_nxt = S_EVAL;
			end
			S_EVAL: begin
				if (slot_free) begin
					cmd.eval = 1'b1;
					if (status.ev_term) begin
						state_nxt = S_IDLE;
					end else if (status.ev_reread) begin
						state_nxt = S_READ;
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_load_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> slot_free)
		else $error("result loaded over an untaken result");

	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> !in_ready)
		else $error("item accepted while another is in progress");

	a_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.simple || cmd.eval))
		else $error("result raised without an executing command");

endmodule

// File: sv/cgs_datapath.sv
module cgs_datapath #(
	parameter int MAX_ELEMENTS = cgs_pkg::MAX_ELEMENTS_DEF,
	parameter int GENOME_WIDTH = cgs_pkg::GENOME_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cgs_pkg::ctrl_cmd_t                cmd,
	output cgs_pkg::dp_status_t               status,
	input  logic [cgs_pkg::OPER_W-1:0]        operation,
	input  logic [cgs_pkg::CIGOP_W-1:0]       element_op,
	input  logic [cgs_pkg::ELEN_W-1:0]        element_length,
	input  logic [cgs_pkg::RLEN_W-1:0]        read_length,
	output logic                              past_end,
	output logic [cgs_pkg::CIGOP_W-1:0]       step_op,
	output logic signed [cgs_pkg::RPOS_W-1:0] read_position,
	output logic signed [cgs_pkg::GPOS_W-1:0] genome_position,
	output logic [cgs_pkg::ERR_W-1:0]         error_code
);
	import cgs_pkg::*;

	localparam int AW      = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int CW      = $clog2(MAX_ELEMENTS + 1);
	localparam int GW      = GENOME_WIDTH;
	localparam int OFFW    = ELEN_W + 1;
	localparam int ENTRY_W = CIGOP_W + ELEN_W;
	localparam int RSUM_W  = ELEN_W + 2;
	localparam int GEXT_W  = 64;
	localparam int READ_MAX = 65535;
	localparam logic [CW-1:0]        CNT_FULL = CW'(MAX_ELEMENTS);
	localparam logic signed [GW-1:0] GEN_MAX  = {1'b0, {(GW-1){1'b1}}};

	// saturating add onto the read cursor
	function automatic logic signed [RPOS_W-1:0] read_add(
		input logic signed [RPOS_W-1:0] cur,
		input logic [ELEN_W-1:0]        n
	);
		logic [RSUM_W-1:0] s;
		s = {{(RSUM_W-RPOS_W){cur[RPOS_W-1]}}, cur} + {{(RSUM_W-ELEN_W){1'b0}}, n};
		if (!s[RSUM_W-1] && (s > RSUM_W'(READ_MAX))) begin
			return RPOS_W'(READ_MAX);
		end
		return s[RPOS_W-1:0];
	endfunction

	// low bits of the sign-extended genome cursor
	function automatic logic signed [GPOS_W-1:0] gen_port(input logic signed [GW-1:0] g);
		logic [GEXT_W-1:0] ext;
		ext = {{(GEXT_W-GW){g[GW-1]}}, g};
		return ext[GPOS_W-1:0];
	endfunction

	// captured item
	logic [OPER_W-1:0]  oper_q;
	logic [CIGOP_W-1:0] eop_q;
	logic [ELEN_W-1:0]  elen_q;
	logic [RLEN_W-1:0]  rlen_q;

	// element table and its read register
	logic [ENTRY_W-1:0] elem_mem [MAX_ELEMENTS];
	logic [ENTRY_W-1:0] rd_q;
	logic [CIGOP_W-1:0] e_op;
	logic [ELEN_W-1:0]  e_len;

	// walk state
	logic [CW-1:0]             cnt_q;
	logic [CW-1:0]             idx_q;
	logic                      idx_none_q;
	logic [OFFW-1:0]           off_q;      // offset in element plus one
	logic signed [RPOS_W-1:0]  read_q;
	logic signed [GW-1:0]      gen_q;
	logic [RLEN_W-1:0]         stored_q;

	// result register
	logic                      past_q;
	logic [CIGOP_W-1:0]        op_out_q;
	logic signed [RPOS_W-1:0]  rpos_q;
	logic signed [GPOS_W-1:0]  gpos_q;
	logic [ERR_W-1:0]          err_q;

	// one evaluation step
	logic                      full;
	logic                      adv;
	logic [CW-1:0]             nxt_idx;
	logic signed [GW-1:0]      gen_bump;
	logic                      ev_term;
	logic                      ev_reread;
	logic                      ev_past;
	logic [CIGOP_W-1:0]        ev_op;
	logic [ERR_W-1:0]          ev_err;
	logic [CW-1:0]             ev_idx;
	logic                      ev_none;
	logic [OFFW-1:0]           ev_off;
	logic signed [RPOS_W-1:0]  ev_read;
	logic signed [GW-1:0]      ev_gen;

	assign e_op     = rd_q[ENTRY_W-1 -: CIGOP_W];
	assign e_len    = rd_q[ELEN_W-1:0];
	assign full     = (cnt_q == CNT_FULL);
	assign nxt_idx  = idx_none_q ? '0 : idx_q + 1'b1;
	assign adv      = idx_none_q || (idx_q >= cnt_q) || (off_q >= {1'b0, e_len});
	assign gen_bump = (gen_q < GEN_MAX) ? gen_q + 1'b1 : gen_q;

	always_comb begin
		ev_term   = 1'b0;
		ev_reread = 1'b0;
		ev_past   = 1'b0;
		ev_op     = CIG_NONE;
		ev_err    = ERR_NONE;
		ev_idx    = idx_q;
		ev_none   = idx_none_q;
		ev_off    = off_q;
		ev_read   = read_q;
		ev_gen    = gen_q;
		if (adv) begin
			if (nxt_idx < cnt_q) begin
				// enter the next element
				ev_idx    = nxt_idx;
				ev_none   = 1'b0;
				ev_off    = '0;
				ev_reread = 1'b1;
			end else begin
				// ran off the end of the cigar
				ev_idx  = '0;
				ev_none = 1'b1;
				ev_off  = OFFW'(1);
				ev_read = {1'b0, stored_q};
				ev_gen  = gen_bump;
				ev_term = 1'b1;
				ev_past = 1'b1;
			end
		end else begin
			ev_off = off_q + 1'b1;
			unique case (e_op)
				CIG_I, CIG_S: begin
					ev_off  = {1'b0, e_len} + 1'b1;
					ev_read = read_add(read_q, e_len);
				end
				CIG_D: begin
					ev_err  = read_q[RPOS_W-1] ? ERR_DEL_FIRST : ERR_NONE;
					ev_gen  = gen_bump;
					ev_term = 1'b1;
					ev_op   = e_op;
				end
				CIG_N: begin
					ev_gen  = gen_bump;
					ev_term = 1'b1;
					ev_op   = e_op;
				end
				CIG_M, CIG_EQ, CIG_X: begin
					ev_read = read_add(read_q, ELEN_W'(1));
					ev_gen  = gen_bump;
					ev_term = 1'b1;
					ev_op   = e_op;
				end
				default: begin
					// hard clips, padding and unknown ops are skipped whole
					ev_off = {1'b0, e_len} + 1'b1;
				end
			endcase
		end
	end

	assign status.in_step   = (operation == OP_STEP);
	assign status.ev_term   = ev_term;
	assign status.ev_reread = ev_reread;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			oper_q <= operation;
			eop_q  <= element_op;
			elen_q <= element_length;
			rlen_q <= read_length;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.simple && (oper_q == OP_APPEND) && !full) begin
			elem_mem[cnt_q[AW-1:0]] <= {eop_q, elen_q};
		end
		if (cmd.read) begin
			rd_q <= elem_mem[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			idx_q      <= '0;
			idx_none_q <= 1'b1;
			off_q      <= OFFW'(1);
			read_q     <= '1;
			gen_q      <= '1;
			stored_q   <= '0;
		end else if (cmd.simple) begin
			unique case (oper_q)
				OP_BEGIN: begin
					cnt_q      <= '0;
					idx_q      <= '0;
					idx_none_q <= 1'b1;
					off_q      <= OFFW'(1);
					read_q     <= '1;
					gen_q      <= '1;
					stored_q   <= rlen_q;
				end
				OP_APPEND: begin
					if (!full) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end else if (cmd.eval) begin
			idx_q      <= ev_idx;
			idx_none_q <= ev_none;
			off_q      <= ev_off;
			read_q     <= ev_read;
			gen_q      <= ev_gen;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.simple) begin
			past_q   <= 1'b0;
			op_out_q <= CIG_NONE;
			if (oper_q == OP_BEGIN) begin
				rpos_q <= '1;
				gpos_q <= '1;
			end else begin
				rpos_q <= read_q;
				gpos_q <= gen_port(gen_q);
			end
			err_q <= ((oper_q == OP_APPEND) && full) ? ERR_FULL : ERR_NONE;
		end else if (cmd.eval && ev_term) begin
			past_q   <= ev_past;
			op_out_q <= ev_op;
			rpos_q   <= ev_read;
			gpos_q   <= gen_port(ev_gen);
			err_q    <= ev_err;
		end
	end

	assign past_end        = past_q;
	assign step_op         = op_out_q;
	assign read_position   = rpos_q;
	assign genome_position = gpos_q;
	assign error_code      = err_q;

	a_index_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		!idx_none_q |-> (idx_q < cnt_q))
		else $error("walk index beyond filled table");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("element count beyond table depth");

	a_read_cursor_floor: assert property (@(posedge clk) disable iff (!arst_n)
		read_q >= -17'sd1)
		else $error("read cursor below minus one");

endmodule

// File: sv/cigar_genome_stepper_top.sv
// channel  | modport | transfer moves
// ---------+---------+-----------------------------------------------------------
// item     | sink    | operation, element_op, element_length, read_length
// result   | source  | past_end, step_op, read_position, genome_position, error_code
//
// begin, append and unused codes go through capture, then a load of the result register
// a step goes through capture, a table read and an evaluation; each element entered adds
// a read and an evaluation, and each whole insertion, clip, padding or unknown-op element
// consumed adds an evaluation (single table read port); reset clears counters, sets the
// cursors to minus one and leaves the table, only filled entries are evaluated; a new item
// is taken while a result waits; execute and evaluation steps stall while it is untaken
module cigar_genome_stepper_top #(
	parameter int MAX_ELEMENTS = cgs_pkg::MAX_ELEMENTS_DEF,
	parameter int GENOME_WIDTH = cgs_pkg::GENOME_WIDTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	cgs_in_if.sink    item,
	cgs_out_if.source result
);
	import cgs_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// sequencer: one item at a time, output register decoupled
	cgs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.status    (status)
	);

	// element table, walk cursors and result register
	cgs_datapath #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.GENOME_WIDTH (GENOME_WIDTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.operation       (item.operation),
		.element_op      (item.element_op),
		.element_length  (item.element_length),
		.read_length     (item.read_length),
		.past_end        (result.past_end),
		.step_op         (result.step_op),
		.read_position   (result.read_position),
		.genome_position (result.genome_position),
		.error_code      (result.error_code)
	);

endmodule

// File: test/tb_cigar_genome_stepper_top.sv
module tb_cigar_genome_stepper_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cgs_pkg::*;

	// block configuration under test
	localparam int MAX_ELEMENTS = MAX_ELEMENTS_DEF;
	localparam int GENOME_WIDTH = GENOME_WIDTH_DEF;

	// run shape
	localparam int RANDOM_ITEMS  = 1600;
	localparam int DRAIN_CYCLES  = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int MAX_PRINTED   = 100;
	localparam longint RUN_LIMIT_NS = 30_000_000;

	// operation code that leaves the block's state unchanged
	localparam logic [OPER_W-1:0] OP_UNUSED = 2'd3;
	// cigar op codes outside the defined set, consumed whole like padding
	localparam logic [CIGOP_W-1:0] CIG_ODD_LO = 4'd9;
	localparam logic [CIGOP_W-1:0] CIG_ODD_HI = 4'd15;
	localparam logic [ELEN_W-1:0]  ELEN_MAX   = '1;
	localparam logic [RLEN_W-1:0]  RLEN_MAX   = '1;

	// saturation points of the two cursors
	localparam longint READ_SAT   = 65535;
	localparam longint GENOME_SAT = (longint'(1) << (GENOME_WIDTH - 1)) - 1;

	// receiver stall pattern, rotated one bit per cycle
	localparam logic [8:0] STALL_PATTERN = 9'b101100111;

	typedef enum int {RDY_OPEN, RDY_COIN, RDY_PATTERN, RDY_RARE} ready_mode_t;

	typedef struct {
		logic [OPER_W-1:0]  operation;
		logic [CIGOP_W-1:0] element_op;
		logic [ELEN_W-1:0]  element_length;
		logic [RLEN_W-1:0]  read_length;
	} cigar_item_t;

	typedef struct packed {
		logic                     past_end;
		logic [CIGOP_W-1:0]       step_op;
		logic signed [RPOS_W-1:0] read_position;
		logic signed [GPOS_W-1:0] genome_position;
		logic [ERR_W-1:0]         error_code;
	} walk_report_t;

	logic clk;
	logic arst_n;

	cgs_in_if  item_ch();
	cgs_out_if result_ch();

	cigar_genome_stepper_top #(
		.MAX_ELEMENTS(MAX_ELEMENTS),
		.GENOME_WIDTH(GENOME_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch)
	);

	// ------------------------------------------------------------------
	// walk predictor: own copy of the element table and the cursors
	// ------------------------------------------------------------------
	logic [CIGOP_W-1:0] walk_op [MAX_ELEMENTS];
	longint             walk_len [MAX_ELEMENTS];
	int                 walk_count;
	int                 walk_index;
	longint             walk_offset;
	longint             walk_read_pos;
	longint             walk_genome_pos;
	longint             walk_read_len;

	// results still owed by the block, oldest first
	walk_report_t awaited_reports [$];

	// bookkeeping for the summary
	int items_sent;
	int ignored_items;
	int steps_sent;
	int reports_checked;
	int mismatches;
	int past_end_seen;
	int early_del_seen;
	int full_seen;
	int read_sat_seen;

	// sender and receiver behaviour, changed by the tests
	bit          gaps_on;
	int          burst_left;
	ready_mode_t ready_mode = RDY_OPEN;
	int          ready_hold = 0;

	// a begin puts the walk before the first element of an empty table
	function automatic void walk_restart(longint read_len);
		walk_count      = 0;
		walk_index      = -1;
		walk_offset     = 0;
		walk_read_pos   = -1;
		walk_genome_pos = -1;
		walk_read_len   = read_len;
	endfunction

	function automatic void genome_advance();
		if (walk_genome_pos < GENOME_SAT)
			walk_genome_pos++;
	endfunction

	function automatic void read_advance(longint n);
		walk_read_pos += n;
		if (walk_read_pos > READ_SAT)
			walk_read_pos = READ_SAT;
	endfunction

	function automatic walk_report_t predict_walk_report(cigar_item_t it);
		walk_report_t r;
		logic [CIGOP_W-1:0] op;
		longint len;
		bit stopped;
		r.past_end   = 1'b0;
		r.step_op    = CIG_NONE;
		r.error_code = ERR_NONE;
		case (it.operation)
			OP_BEGIN: begin
				walk_restart(it.read_length);
			end
			OP_APPEND: begin
				if (walk_count >= MAX_ELEMENTS) begin
					r.error_code = ERR_FULL;
				end else begin
					walk_op[walk_count]  = it.element_op;
					walk_len[walk_count] = it.element_length;
					walk_count++;
				end
			end
			OP_STEP: begin
				stopped = 1'b0;
				while (!stopped) begin
					if (walk_index < 0 || walk_index >= walk_count ||
							walk_offset + 1 >= walk_len[walk_index]) begin
						// current element used up: move on, or fall off the end
						walk_index++;
						if (walk_index >= 0 && walk_index < walk_count) begin
							walk_offset = -1;
						end else begin
							walk_offset   = 0;
							walk_index    = -1;
							walk_read_pos = walk_read_len;
							genome_advance();
							r.past_end = 1'b1;
							stopped    = 1'b1;
						end
					end else begin
						op  = walk_op[walk_index];
						len = walk_len[walk_index];
						walk_offset++;
						case (op)
							CIG_I, CIG_S: begin
								walk_offset = len;
								read_advance(len);
							end
							CIG_D: begin
								if (walk_read_pos < 0)
									r.error_code = ERR_DEL_FIRST;
								genome_advance();
								r.step_op = op;
								stopped   = 1'b1;
							end
							CIG_N: begin
								genome_advance();
								r.step_op = op;
								stopped   = 1'b1;
							end
							CIG_M, CIG_EQ, CIG_X: begin
								read_advance(1);
								genome_advance();
								r.step_op = op;
								stopped   = 1'b1;
							end
							default: begin
								walk_offset = len;
							end
						endcase
					end
				end
			end
			default: ;
		endcase
		r.read_position   = walk_read_pos[RPOS_W-1:0];
		r.genome_position = walk_genome_pos[GPOS_W-1:0];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// clock, and the receiver that paces the result channel
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ready changes only at the falling edge; a requested hold-off is counted here
	initial begin
		int phase;
		phase = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			phase++;
			if (ready_hold > 0) begin
				ready_hold--;
				result_ch.ready <= 1'b0;
			end else begin
				case (ready_mode)
					RDY_OPEN:    result_ch.ready <= 1'b1;
					RDY_COIN:    result_ch.ready <= 1'($urandom_range(0, 1));
					RDY_PATTERN: result_ch.ready <= STALL_PATTERN[phase % 9];
					default:     result_ch.ready <= ($urandom_range(0, 15) != 0);
				endcase
			end
		end
	end

	// every result transfer is matched against the oldest prediction
	always @(posedge clk) begin
		walk_report_t got;
		walk_report_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = {result_ch.past_end, result_ch.step_op, result_ch.read_position,
				result_ch.genome_position, result_ch.error_code};
			reports_checked++;
			if (awaited_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_PRINTED)
					$display("%0t: result with nothing owed: end=%0b op=%0d rd=%0d gn=%0d err=%0d",
						$time, got.past_end, got.step_op, got.read_position,
						got.genome_position, got.error_code);
			end else begin
				want = awaited_reports.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= MAX_PRINTED)
						$display({"%0t: mismatch, expected end=%0b op=%0d rd=%0d gn=%0d err=%0d,",
							" got end=%0b op=%0d rd=%0d gn=%0d err=%0d"}, $time,
							want.past_end, want.step_op, want.read_position,
							want.genome_position, want.error_code,
							got.past_end, got.step_op, got.read_position,
							got.genome_position, got.error_code);
				end
				if (want.past_end)
					past_end_seen++;
				if (want.error_code == ERR_DEL_FIRST)
					early_del_seen++;
				if (want.error_code == ERR_FULL)
					full_seen++;
				if (want.read_position == READ_SAT)
					read_sat_seen++;
			end
		end
	end

	// ------------------------------------------------------------------
	// item sender: bursts of transfers with random gaps between them
	// ------------------------------------------------------------------
	task automatic send_item(cigar_item_t it);
		int gap;
		if (gaps_on && burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = $urandom_range(1, 6);
			@(negedge clk);
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		item_ch.valid          <= 1'b1;
		item_ch.operation      <= it.operation;
		item_ch.element_op     <= it.element_op;
		item_ch.element_length <= it.element_length;
		item_ch.read_length    <= it.read_length;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		// transfer taken at this edge: predict its result now
		awaited_reports.push_back(predict_walk_report(it));
		if (burst_left > 0)
			burst_left--;
		items_sent++;
		if (it.operation == OP_UNUSED)
			ignored_items++;
		if (it.operation == OP_STEP)
			steps_sent++;
	endtask

	task automatic sender_idle();
		@(negedge clk);
		item_ch.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (awaited_reports.size() != 0)
			@(posedge clk);
	endtask

	// unused fields of an item carry random values
	function automatic cigar_item_t random_item(logic [OPER_W-1:0] operation);
		cigar_item_t it;
		it.operation      = operation;
		it.element_op     = CIGOP_W'($urandom());
		it.element_length = ELEN_W'($urandom());
		it.read_length    = RLEN_W'($urandom());
		return it;
	endfunction

	task automatic send_begin(logic [RLEN_W-1:0] read_len);
		cigar_item_t it;
		it = random_item(OP_BEGIN);
		it.read_length = read_len;
		send_item(it);
	endtask

	task automatic send_append(logic [CIGOP_W-1:0] op, logic [ELEN_W-1:0] len);
		cigar_item_t it;
		it = random_item(OP_APPEND);
		it.element_op     = op;
		it.element_length = len;
		send_item(it);
	endtask

	task automatic send_step();
		send_item(random_item(OP_STEP));
	endtask

	// match-like ops most often, now and then one of the undefined codes
	function automatic logic [CIGOP_W-1:0] pick_element_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) return CIG_M;
		if (r < 40) return CIG_I;
		if (r < 50) return CIG_D;
		if (r < 56) return CIG_N;
		if (r < 66) return CIG_S;
		if (r < 72) return CIG_H;
		if (r < 77) return CIG_P;
		if (r < 84) return CIG_EQ;
		if (r < 92) return CIG_X;
		return CIGOP_W'($urandom_range(CIG_ODD_LO, CIG_ODD_HI));
	endfunction

	// short elements for the most part, zero often, the full width now and then
	function automatic logic [ELEN_W-1:0] pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12) return '0;
		if (r < 80) return ELEN_W'($urandom_range(1, 5));
		if (r < 92) return ELEN_W'($urandom_range(6, 30));
		return ELEN_W'($urandom());
	endfunction

	// one read: begin, a cigar, then steps enough to walk it and run off the end unless capped by max_steps
	task automatic run_read_walk(int max_steps);
		int n_elem;
		int span;
		logic [CIGOP_W-1:0] op;
		logic [ELEN_W-1:0] len;
		if ($urandom_range(0, 1))
			send_begin(RLEN_W'($urandom_range(0, 200)));
		else
			send_begin(RLEN_W'($urandom()));
		// now and then a cigar near the table depth, long enough at times to fill and overflow it
		if ($urandom_range(0, 24) == 0)
			n_elem = $urandom_range(MAX_ELEMENTS - 4, MAX_ELEMENTS + 4);
		else
			n_elem = $urandom_range(0, 10);
		span = 0;
		repeat (n_elem) begin
			op  = pick_element_op();
			len = pick_length();
			if (op inside {CIG_M, CIG_D, CIG_N, CIG_EQ, CIG_X})
				span += (len > max_steps) ? max_steps : int'(len);
			send_append(op, len);
		end
		if (span > max_steps)
			span = max_steps;
		repeat (span + $urandom_range(1, 4))
			send_step();
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// hand-built cigar touching every op, the field extremes and the odd cases
	task automatic test_directed_walk();
		gaps_on    = 1'b0;
		ready_mode = RDY_OPEN;
		// step with an empty table straight after reset runs off the end
		send_step();
		// the spare operation code leaves the walk unchanged
		send_item(random_item(OP_UNUSED));
		send_begin(RLEN_MAX);
		// deletion before any read base, then elements that are consumed whole
		send_append(CIG_D, 2);
		send_append(CIG_H, 0);
		send_append(CIG_P, 1);
		send_append(CIG_ODD_HI, 3);
		// widest soft clip drives the read offset into saturation
		send_append(CIG_S, ELEN_MAX);
		send_append(CIG_I, 1);
		send_append(CIG_M, 1);
		send_append(CIG_N, 1);
		send_append(CIG_EQ, 1);
		send_append(CIG_X, 2);
		// zero-length trailing element is skipped
		send_append(CIG_I, 0);
		// two deletion bases, the matches, past the end, then a restart from the top
		repeat (11)
			send_step();
		sender_idle();
		wait_drained();
	endtask

	// fill the table to the brim, overflow it, then step into the start of the full table
	task automatic test_table_full();
		gaps_on    = 1'b1;
		ready_mode = RDY_COIN;
		send_begin(RLEN_W'($urandom()));
		repeat (MAX_ELEMENTS)
			send_append(pick_element_op(), pick_length());
		repeat (3)
			send_append(CIGOP_W'($urandom()), ELEN_W'($urandom()));
		repeat (6)
			send_step();
		sender_idle();
		wait_drained();
	endtask

	// result side held off for a long stretch while items keep coming
	task automatic test_backpressure();
		gaps_on    = 1'b0;
		ready_mode = RDY_OPEN;
		ready_hold = HOLD_CYCLES;
		run_read_walk(30);
		sender_idle();
		wait_drained();
	endtask

	// mostly well-formed reads with random content, some raw noise in between
	task automatic test_random_walks();
		int counted_from;
		counted_from = items_sent - ignored_items;
		while (items_sent - ignored_items - counted_from < RANDOM_ITEMS) begin
			ready_mode = ready_mode_t'($urandom_range(0, 3));
			gaps_on    = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 6) == 0) begin
				repeat ($urandom_range(1, 8))
					send_item(random_item(OPER_W'($urandom_range(0, 3))));
			end else begin
				run_read_walk($urandom_range(8, 40));
			end
			// sometimes let the pipeline empty completely before going on
			if ($urandom_range(0, 9) == 0) begin
				sender_idle();
				wait_drained();
			end
		end
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		item_ch.valid          = 1'b0;
		item_ch.operation      = OP_BEGIN;
		item_ch.element_op     = CIG_M;
		item_ch.element_length = '0;
		item_ch.read_length    = '0;
		arst_n                 = 1'b0;
		gaps_on                = 1'b0;
		burst_left             = 0;
		walk_restart(0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_walk();
		test_table_full();
		test_backpressure();
		test_random_walks();

		// everything sent: collect what is owed, then watch for stray results
		sender_idle();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run: %0d items (%0d steps), %0d results checked",
			items_sent, steps_sent, reports_checked);
		$display("run: %0d past-end, %0d early deletions, %0d table-full, %0d saturated reads",
			past_end_seen, early_del_seen, full_seen, read_sat_seen);
		if (mismatches == 0)
			$display("tb_cigar_genome_stepper_top: done, clean");
		else
			$display("tb_cigar_genome_stepper_top: done, errors");
		$finish;
	end

	// watchdog against a hung handshake
	initial begin
		#(RUN_LIMIT_NS);
		$display("%0t: run limit reached, %0d results still owed", $time, awaited_reports.size());
		$display("tb_cigar_genome_stepper_top: done, errors");
		$finish;
	end

endmodule

// File: cigar_genome_stepper_top.f
sv/cgs_pkg.sv
sv/cgs_in_if.sv
sv/cgs_out_if.sv
sv/cgs_ctrl.sv
sv/cgs_datapath.sv
sv/cigar_genome_stepper_top.sv
test/tb_cigar_genome_stepper_top.sv
